[hdl/kea_pkg.sv]
// Shared constants, types and the arctangent table of the kappa/Eulerian angle converter.
`default_nettype none

package kea_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned ASHIFT     = 32 - ANGLE_BITS;
  localparam logic [31:0] ROUND_BIAS = (ASHIFT > 0) ? (32'd1 << (ASHIFT - 1)) : 32'd0;

  localparam int unsigned STEPS      = 30;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned ROOT_STEPS = 31;
  localparam int unsigned VW         = 34;

  localparam int unsigned TILT_W     = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = TILT_W;

  localparam logic [CFG_IDX_W-1:0] REG_KAPPA_TILT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOLUTION_BRANCH = 1'd1;

  localparam logic [TILT_W-1:0] TILT_RESET = 14'd9102;
  localparam logic              SOL_RESET  = 1'b1;

  localparam logic signed [VW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [VW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0]          QUARTER     = 32'h4000_0000;
  localparam logic [31:0]          HALF        = 32'h8000_0000;

  localparam int unsigned SC_LAT   = STEPS + 2;
  localparam int unsigned DIV_LAT  = DIV_STEPS + 2;
  localparam int unsigned ROOT_LAT = ROOT_STEPS + 2;
  localparam int unsigned AT_LAT   = STEPS + 2;
  localparam int unsigned CTX_LAT  = SC_LAT + 1 + DIV_LAT + ROOT_LAT + AT_LAT;

  typedef logic signed [VW-1:0]         val_t;
  typedef logic [31:0]                  ang_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic command;
    logic branch;
    ang_t a1;
    ang_t a3;
    logic status;
  } ctx_t;

  function automatic val_t atan_step(input int unsigned i);
    val_t r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/kea_intf.sv]
// Channel interfaces of the converter: input items, result items and register writes.
`default_nettype none

interface kea_in_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  kea_pkg::angle_t      first_angle;
  kea_pkg::angle_t      second_angle;
  kea_pkg::angle_t      third_angle;
  modport source (output valid, command, first_angle, second_angle, third_angle, input ready);
  modport sink   (input valid, command, first_angle, second_angle, third_angle, output ready);
endinterface

interface kea_out_if;
  logic                 valid;
  logic                 ready;
  kea_pkg::angle_t      first_result;
  kea_pkg::angle_t      second_result;
  kea_pkg::angle_t      third_result;
  logic                 status;
  modport source (output valid, first_result, second_result, third_result, status, input ready);
  modport sink   (input valid, first_result, second_result, third_result, status, output ready);
endinterface

interface kea_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kea_pkg::CFG_IDX_W-1:0]     index;
  logic [kea_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/kappa_eulerian_angle_convert.sv]
// Top level of the kappa/Eulerian goniometer angle converter.
//
//   Channel  Dir  Handshake     Payload
//   in_i     in   valid/ready   command, first_angle, second_angle, third_angle
//   out_o    out  valid/ready   first_result, second_result, third_result, status
//   cfg_i    in   valid/ready   index, data (0: kappa_tilt, 1: solution_branch)
//
// One item enters per cycle unless the pipeline is frozen; each result passes through the
// input stage, two 32-stage sine/cosine CORDICs, a multiply stage, two 33-stage
// dividers, two 33-stage square roots, two 32-stage arctangent CORDICs, output stage.
// Reset sets the tilt to fifty degrees and the solution branch to one.
// A full output register with ready low freezes every stage while a finished item waits at
// the end of the pipeline; while that end slot is empty, the stages still move up.
`default_nettype none

module kappa_eulerian_angle_convert (
  input  logic             clk_i,
  input  logic             rst_ni,
  kea_cfg_if.sink          cfg_i,
  kea_in_if.sink           in_i,
  kea_out_if.source        out_o
);

  typedef struct packed {
    kea_pkg::val_t m_sh_ca;
    kea_pkg::val_t m_sh_sa;
    kea_pkg::val_t ch;
  } side_a_t;

  typedef struct packed {
    kea_pkg::val_t m_sh_ca;
    kea_pkg::val_t ch;
  } side_b_t;

  localparam int unsigned VW      = kea_pkg::VW;
  localparam int unsigned TAP_DIV = kea_pkg::SC_LAT + kea_pkg::DIV_LAT;
  localparam int unsigned TAP_RT  = TAP_DIV + kea_pkg::ROOT_LAT;

  function automatic kea_pkg::angle_t round_angle(input kea_pkg::ang_t v);
    kea_pkg::ang_t s;
    s = v + kea_pkg::ROUND_BIAS;
    return kea_pkg::angle_t'(s >> kea_pkg::ASHIFT);
  endfunction

  logic [kea_pkg::TILT_W-1:0] tilt_q;
  logic                       sol_q;
  logic                       en;

  // Input stage.
  logic          v0_q;
  kea_pkg::ctx_t ctx0_d, ctx0_q;
  kea_pkg::ang_t tilt_ang_q, half_q;
  kea_pkg::ang_t a2;
  logic [32:0]   chi_abs;
  logic [32:0]   two_tilt;

  // Sine/cosine outputs.
  logic          sc_t_v, sc_h_v;
  kea_pkg::val_t sa, ca, sh, ch;

  // Multiply stage.
  logic                     v1_q;
  logic signed [2*VW-1:0]   p_sh_ca, p_sh_sa, p_ch_sa;
  kea_pkg::val_t            m_sh_ca_q, m_sh_sa_q, m_ch_sa_q, sh_q, sa_q, ch_q;

  // Dividers, roots, arctangents.
  logic          rat_p_v, rat_k_v;
  kea_pkg::val_t rat_p, rat_k;
  logic          rt_p_v, rt_k_v;
  kea_pkg::val_t rt_k_in;
  kea_pkg::val_t sin_p, root_p, sin_k, root_k;
  logic          at_p_v, at_k_v;
  kea_pkg::val_t at_p_y, at_p_x;
  kea_pkg::ang_t ang_p, ang_k;

  kea_pkg::ctx_t ctx_q  [kea_pkg::CTX_LAT];
  side_a_t       sda_q  [kea_pkg::DIV_LAT];
  side_b_t       sdb_q  [kea_pkg::ROOT_LAT];
  side_a_t       sda_d;
  kea_pkg::ctx_t ctx_n;

  // Output stage.
  kea_pkg::ang_t   two, r1, r2, r3;
  logic            out_v_q;
  kea_pkg::angle_t res1_q, res2_q, res3_q;
  logic            status_q;

  // Register writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= kea_pkg::TILT_RESET;
      sol_q  <= kea_pkg::SOL_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kea_pkg::REG_KAPPA_TILT:      tilt_q <= cfg_i.data;
        kea_pkg::REG_SOLUTION_BRANCH: sol_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished item would overwrite a result not yet taken.
  assign en         = out_o.ready || !out_v_q || !at_k_v;
  assign in_i.ready = en;

  always_comb begin
    a2              = 32'(unsigned'(in_i.second_angle)) << kea_pkg::ASHIFT;
    chi_abs         = a2[31] ? (33'd0 - {1'b1, a2}) : {1'b0, a2};
    two_tilt        = 33'(tilt_q) << 17;
    ctx0_d.command  = in_i.command;
    ctx0_d.branch   = sol_q;
    ctx0_d.a1       = 32'(unsigned'(in_i.first_angle)) << kea_pkg::ASHIFT;
    ctx0_d.a3       = 32'(unsigned'(in_i.third_angle)) << kea_pkg::ASHIFT;
    ctx0_d.status   = in_i.command && (chi_abs > two_tilt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= sc_t_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx0_q     <= ctx0_d;
      tilt_ang_q <= 32'(tilt_q) << 16;
      half_q     <= {a2[31], a2[31:1]};
    end
  end

  kea_sincos u_sc_tilt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .angle_i(tilt_ang_q),
    .valid_o(sc_t_v), .sin_o(sa), .cos_o(ca)
  );

  kea_sincos u_sc_half (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .angle_i(half_q),
    .valid_o(sc_h_v), .sin_o(sh), .cos_o(ch)
  );

  assign p_sh_ca = (2*VW)'(sh) * (2*VW)'(ca);
  assign p_sh_sa = (2*VW)'(sh) * (2*VW)'(sa);
  assign p_ch_sa = (2*VW)'(ch) * (2*VW)'(sa);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sh_ca_q <= VW'(p_sh_ca >>> 30);
      m_sh_sa_q <= VW'(p_sh_sa >>> 30);
      m_ch_sa_q <= VW'(p_ch_sa >>> 30);
      sh_q      <= sh;
      sa_q      <= sa;
      ch_q      <= ch;
    end
  end

  kea_ratio u_rat_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .num_i(m_sh_ca_q), .den_i(m_ch_sa_q),
    .valid_o(rat_p_v), .ratio_o(rat_p)
  );

  kea_ratio u_rat_k (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .num_i(sh_q), .den_i(sa_q),
    .valid_o(rat_k_v), .ratio_o(rat_k)
  );

  // The kappa to Eulerian direction takes the sine of half kappa times the tilt sine directly.
  assign rt_k_in = ctx_q[TAP_DIV].command ? rat_k : sda_q[kea_pkg::DIV_LAT-1].m_sh_sa;

  kea_asin_root u_rt_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rat_p_v), .sine_i(rat_p),
    .valid_o(rt_p_v), .sine_o(sin_p), .root_o(root_p)
  );

  kea_asin_root u_rt_k (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rat_k_v), .sine_i(rt_k_in),
    .valid_o(rt_k_v), .sine_o(sin_k), .root_o(root_k)
  );

  assign at_p_y = ctx_q[TAP_RT].command ? sin_p  : sdb_q[kea_pkg::ROOT_LAT-1].m_sh_ca;
  assign at_p_x = ctx_q[TAP_RT].command ? root_p : sdb_q[kea_pkg::ROOT_LAT-1].ch;

  kea_atan2 u_at_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_p_v), .y_i(at_p_y), .x_i(at_p_x),
    .valid_o(at_p_v), .angle_o(ang_p)
  );

  kea_atan2 u_at_k (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_k_v), .y_i(sin_k), .x_i(root_k),
    .valid_o(at_k_v), .angle_o(ang_k)
  );

  // Side data travels beside the arithmetic units.
  always_comb begin
    sda_d.m_sh_ca = m_sh_ca_q;
    sda_d.m_sh_sa = m_sh_sa_q;
    sda_d.ch      = ch_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx0_q;
      for (int j = 1; j < kea_pkg::CTX_LAT; j++) begin
        ctx_q[j] <= ctx_q[j-1];
      end
      sda_q[0] <= sda_d;
      for (int j = 1; j < kea_pkg::DIV_LAT; j++) begin
        sda_q[j] <= sda_q[j-1];
      end
      sdb_q[0].m_sh_ca <= sda_q[kea_pkg::DIV_LAT-1].m_sh_ca;
      sdb_q[0].ch      <= sda_q[kea_pkg::DIV_LAT-1].ch;
      for (int j = 1; j < kea_pkg::ROOT_LAT; j++) begin
        sdb_q[j] <= sdb_q[j-1];
      end
    end
  end

  // Final angle sums for both directions and both branches.
  always_comb begin
    ctx_n = ctx_q[kea_pkg::CTX_LAT-1];
    two   = {ang_k[30:0], 1'b0};
    if (!ctx_n.command) begin
      if (ctx_n.branch) begin
        r1 = ctx_n.a1 + ang_p - kea_pkg::QUARTER;
        r2 = two;
        r3 = ctx_n.a3 + ang_p + kea_pkg::QUARTER;
      end else begin
        r1 = ctx_n.a1 + ang_p + kea_pkg::QUARTER;
        r2 = 32'd0 - two;
        r3 = ctx_n.a3 + ang_p - kea_pkg::QUARTER;
      end
    end else begin
      if (ctx_n.branch) begin
        r1 = ctx_n.a1 - ang_p + kea_pkg::QUARTER;
        r2 = two;
        r3 = ctx_n.a3 - ang_p - kea_pkg::QUARTER;
      end else begin
        r1 = ctx_n.a1 + ang_p - kea_pkg::QUARTER;
        r2 = 32'd0 - two;
        r3 = ctx_n.a3 + ang_p + kea_pkg::QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_o.ready || !out_v_q) begin
      out_v_q <= at_k_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_o.ready || !out_v_q) begin
      res1_q   <= ctx_n.status ? '0 : round_angle(r1);
      res2_q   <= ctx_n.status ? '0 : round_angle(r2);
      res3_q   <= ctx_n.status ? '0 : round_angle(r3);
      status_q <= ctx_n.status;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.first_result  = res1_q;
  assign out_o.second_result = res2_q;
  assign out_o.third_result  = res3_q;
  assign out_o.status        = status_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_t_v == sc_h_v) && (rat_p_v == rat_k_v) && (rt_p_v == rt_k_v) && (at_p_v == at_k_v))
    else $error("parallel pipeline lanes lost step");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |->
      (out_o.first_result == '0) && (out_o.second_result == '0) && (out_o.third_result == '0))
    else $error("out of reach result carries nonzero angles");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready && at_k_v) |=> at_k_v)
    else $error("finished item dropped during stall");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready && at_k_v) |-> !in_i.ready)
    else $error("input taken while pipeline is frozen");

endmodule

`default_nettype wire

[hdl/kea_sincos.sv]
// Pipelined rotation CORDIC giving the sine and cosine of a 32-bit binary angle.
`default_nettype none

module kea_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  kea_pkg::ang_t angle_i,
  output logic          valid_o,
  output kea_pkg::val_t sin_o,
  output kea_pkg::val_t cos_o
);

  localparam int unsigned N = kea_pkg::STEPS;

  logic [N+1:0]  v_q;
  kea_pkg::val_t x_d [N+1];
  kea_pkg::val_t y_d [N+1];
  kea_pkg::val_t z_d [N+1];
  logic          f_d [N+1];
  kea_pkg::val_t x_q [N+1];
  kea_pkg::val_t y_q [N+1];
  kea_pkg::val_t z_q [N+1];
  logic          f_q [N+1];
  kea_pkg::ang_t turned;
  kea_pkg::ang_t a_rot;
  kea_pkg::val_t sin_q, cos_q;

  always_comb begin
    // Angles in the left half plane are mirrored by a half turn and the result negated.
    turned = angle_i + kea_pkg::QUARTER;
    a_rot  = turned[31] ? (angle_i ^ kea_pkg::HALF) : angle_i;
    x_d[0] = kea_pkg::CORDIC_GAIN;
    y_d[0] = '0;
    z_d[0] = kea_pkg::VW'(signed'(a_rot));
    f_d[0] = turned[31];
    for (int k = 0; k < N; k++) begin
      if (!z_q[k][kea_pkg::VW-1]) begin
        x_d[k+1] = x_q[k] - (y_q[k] >>> k);
        y_d[k+1] = y_q[k] + (x_q[k] >>> k);
        z_d[k+1] = z_q[k] - kea_pkg::atan_step(k);
      end else begin
        x_d[k+1] = x_q[k] + (y_q[k] >>> k);
        y_d[k+1] = y_q[k] - (x_q[k] >>> k);
        z_d[k+1] = z_q[k] + kea_pkg::atan_step(k);
      end
      f_d[k+1] = f_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= N; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
        f_q[k] <= f_d[k];
      end
      sin_q <= f_q[N] ? -y_q[N] : y_q[N];
      cos_q <= f_q[N] ? -x_q[N] : x_q[N];
    end
  end

  assign valid_o = v_q[N+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

`default_nettype wire

[hdl/kea_ratio.sv]
// Pipelined restoring divider giving num * 2^30 / den, truncated and clamped to [-1, 1].
`default_nettype none

module kea_ratio (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  kea_pkg::val_t num_i,
  input  kea_pkg::val_t den_i,
  output logic          valid_o,
  output kea_pkg::val_t ratio_o
);

  localparam int unsigned N  = kea_pkg::DIV_STEPS;
  localparam int unsigned VW = kea_pkg::VW;

  logic [N+1:0]  v_q;
  logic [VW-1:0] r_d   [N+1];
  logic [VW-1:0] r_q   [N+1];
  logic [VW-1:0] den_d [N+1];
  logic [VW-1:0] den_q [N+1];
  logic [N-1:0]  q_d   [N+1];
  logic [N-1:0]  q_q   [N+1];
  logic          pos_d [N+1];
  logic          pos_q [N+1];
  logic          neg_d [N+1];
  logic          neg_q [N+1];
  logic          big_d [N+1];
  logic          big_q [N+1];
  logic [VW-1:0] mag_in;
  logic [VW-1:0] t;
  logic          qb;
  kea_pkg::val_t mag;
  kea_pkg::val_t ratio_d, ratio_q;

  always_comb begin
    mag_in   = num_i[VW-1] ? VW'(-num_i) : VW'(num_i);
    pos_d[0] = (den_i > 0);
    neg_d[0] = num_i[VW-1];
    den_d[0] = VW'(den_i);
    // A quotient of two or more saturates anyway, so the steps only see a remainder below 2*den.
    big_d[0] = pos_d[0] && ({1'b0, mag_in} >= {den_d[0], 1'b0});
    r_d[0]   = (big_d[0] || !pos_d[0]) ? '0 : mag_in;
    q_d[0]   = '0;
    t        = '0;
    qb       = 1'b0;
    for (int k = 0; k < N; k++) begin
      t          = (k == 0) ? r_q[k] : (r_q[k] << 1);
      qb         = (t >= den_q[k]);
      r_d[k+1]   = qb ? (t - den_q[k]) : t;
      q_d[k+1]   = {q_q[k][N-2:0], qb};
      den_d[k+1] = den_q[k];
      pos_d[k+1] = pos_q[k];
      neg_d[k+1] = neg_q[k];
      big_d[k+1] = big_q[k];
    end
    if (big_q[N] || (VW'(q_q[N]) > kea_pkg::ONE_Q30)) begin
      mag = kea_pkg::ONE_Q30;
    end else begin
      mag = VW'(q_q[N]);
    end
    if (!pos_q[N]) begin
      ratio_d = '0;
    end else begin
      ratio_d = neg_q[N] ? -mag : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= N; k++) begin
        r_q[k]   <= r_d[k];
        q_q[k]   <= q_d[k];
        den_q[k] <= den_d[k];
        pos_q[k] <= pos_d[k];
        neg_q[k] <= neg_d[k];
        big_q[k] <= big_d[k];
      end
      ratio_q <= ratio_d;
    end
  end

  assign valid_o = v_q[N+1];
  assign ratio_o = ratio_q;

endmodule

`default_nettype wire

[hdl/kea_asin_root.sv]
// Clamps a Q30 sine to [-1, 1] and computes its cosine as a bitwise integer square root.
`default_nettype none

module kea_asin_root (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  kea_pkg::val_t sine_i,
  output logic          valid_o,
  output kea_pkg::val_t sine_o,
  output kea_pkg::val_t root_o
);

  localparam int unsigned N  = kea_pkg::ROOT_STEPS;
  localparam int unsigned RW = 62;
  localparam logic [RW-1:0] ONE_SQ = 62'd1 << 60;

  logic [N+1:0]  v_q;
  kea_pkg::val_t sat_d, sat_q;
  logic [30:0]   mag_d, mag_q;
  logic [RW-1:0] sq;
  logic [RW-1:0] rem_d [N+1];
  logic [RW-1:0] rem_q [N+1];
  logic [RW-1:0] r_d   [N+1];
  logic [RW-1:0] r_q   [N+1];
  kea_pkg::val_t s_d   [N+1];
  kea_pkg::val_t s_q   [N+1];
  logic [RW-1:0] bitv;
  logic [RW-1:0] trial;

  always_comb begin
    if (sine_i > kea_pkg::ONE_Q30) begin
      sat_d = kea_pkg::ONE_Q30;
    end else if (sine_i < -kea_pkg::ONE_Q30) begin
      sat_d = -kea_pkg::ONE_Q30;
    end else begin
      sat_d = sine_i;
    end
    mag_d    = sat_d[kea_pkg::VW-1] ? 31'(-sat_d) : 31'(sat_d);
    sq       = RW'(mag_q) * RW'(mag_q);
    rem_d[0] = ONE_SQ - sq;
    r_d[0]   = '0;
    s_d[0]   = sat_q;
    bitv     = '0;
    trial    = '0;
    for (int k = 0; k < N; k++) begin
      bitv  = ONE_SQ >> (2 * k);
      trial = r_q[k] + bitv;
      if (rem_q[k] >= trial) begin
        rem_d[k+1] = rem_q[k] - trial;
        r_d[k+1]   = (r_q[k] >> 1) + bitv;
      end else begin
        rem_d[k+1] = rem_q[k];
        r_d[k+1]   = r_q[k] >> 1;
      end
      s_d[k+1] = s_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= sat_d;
      mag_q <= mag_d;
      for (int k = 0; k <= N; k++) begin
        rem_q[k] <= rem_d[k];
        r_q[k]   <= r_d[k];
        s_q[k]   <= s_d[k];
      end
    end
  end

  assign valid_o = v_q[N+1];
  assign sine_o  = s_q[N];
  assign root_o  = kea_pkg::VW'(r_q[N]);

endmodule

`default_nettype wire

[hdl/kea_atan2.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) as a 32-bit binary angle.
`default_nettype none

module kea_atan2 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  kea_pkg::val_t y_i,
  input  kea_pkg::val_t x_i,
  output logic          valid_o,
  output kea_pkg::ang_t angle_o
);

  localparam int unsigned N = kea_pkg::STEPS;

  logic [N+1:0]  v_q;
  kea_pkg::val_t x_d [N+1];
  kea_pkg::val_t y_d [N+1];
  kea_pkg::val_t z_d [N+1];
  kea_pkg::val_t x_q [N+1];
  kea_pkg::val_t y_q [N+1];
  kea_pkg::val_t z_q [N+1];
  kea_pkg::ang_t b_d [N+1];
  kea_pkg::ang_t b_q [N+1];
  logic          zero_d [N+1];
  logic          zero_q [N+1];
  logic          neg;
  kea_pkg::ang_t angle_d, angle_q;

  always_comb begin
    // Vectors in the left half plane are turned by a half turn first.
    neg       = x_i[kea_pkg::VW-1];
    x_d[0]    = neg ? -x_i : x_i;
    y_d[0]    = neg ? -y_i : y_i;
    z_d[0]    = '0;
    b_d[0]    = neg ? kea_pkg::HALF : '0;
    zero_d[0] = (x_i == '0) && (y_i == '0);
    for (int k = 0; k < N; k++) begin
      if (!y_q[k][kea_pkg::VW-1]) begin
        x_d[k+1] = x_q[k] + (y_q[k] >>> k);
        y_d[k+1] = y_q[k] - (x_q[k] >>> k);
        z_d[k+1] = z_q[k] + kea_pkg::atan_step(k);
      end else begin
        x_d[k+1] = x_q[k] - (y_q[k] >>> k);
        y_d[k+1] = y_q[k] + (x_q[k] >>> k);
        z_d[k+1] = z_q[k] - kea_pkg::atan_step(k);
      end
      b_d[k+1]    = b_q[k];
      zero_d[k+1] = zero_q[k];
    end
    angle_d = zero_q[N] ? '0 : (b_q[N] + z_q[N][31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= N; k++) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        z_q[k]    <= z_d[k];
        b_q[k]    <= b_d[k];
        zero_q[k] <= zero_d[k];
      end
      angle_q <= angle_d;
    end
  end

  assign valid_o = v_q[N+1];
  assign angle_o = angle_q;

endmodule

`default_nettype wire
